// ===== design/tdmh_pkg.sv =====
// ----------------------------------------------------------------------------
// tdmh_pkg
// Shared types and codes of the timer deadline min-heap: the heap entry,
// result status codes, datapath operation codes and control/status bundles.
// ----------------------------------------------------------------------------
package tdmh_pkg;

    localparam int TIME_W = 48;
    localparam int ID_W   = 16;
    localparam int ARG_W  = 32;
    localparam int PE_W   = 16;

    typedef struct packed {
        logic [TIME_W-1:0] deadline;
        logic [ID_W-1:0]   handler;
        logic [ARG_W-1:0]  arg;
        logic [PE_W-1:0]   pe;
    } entry_t;

    typedef logic [1:0] status_t;

    localparam status_t ST_SCHEDULED = 2'd0;
    localparam status_t ST_FULL      = 2'd1;
    localparam status_t ST_DUE       = 2'd2;
    localparam status_t ST_NONE      = 2'd3;

    typedef logic [3:0] op_t;

    localparam op_t OP_NONE       = 4'd0;
    localparam op_t OP_ACCEPT     = 4'd1;
    localparam op_t OP_SCHED      = 4'd2;
    localparam op_t OP_RD_PARENT  = 4'd3;
    localparam op_t OP_UP_MOVE    = 4'd4;
    localparam op_t OP_WR_CUR     = 4'd5;
    localparam op_t OP_RD_ROOT    = 4'd6;
    localparam op_t OP_POP        = 4'd7;
    localparam op_t OP_LOAD_LAST  = 4'd8;
    localparam op_t OP_RD_LEFT    = 4'd9;
    localparam op_t OP_TAKE_LEFT  = 4'd10;
    localparam op_t OP_TAKE_RIGHT = 4'd11;
    localparam op_t OP_DOWN_MOVE  = 4'd12;
    localparam op_t OP_EMIT       = 4'd13;

    typedef struct packed {
        op_t     op;
        status_t res_status;
        logic    res_pend;
        logic    res_last;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic count_zero;
        logic hole_root;
        logic up_less;
        logic due;
        logic pend_valid;
        logic child_over;
        logic right_exists;
        logic right_less;
        logic down_stop;
        logic out_free;
    } stat_t;

endpackage

// ===== design/tdmh_ram.sv =====
// ----------------------------------------------------------------------------
// tdmh_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tdmh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/tdmh_dp.sv =====
// ----------------------------------------------------------------------------
// tdmh_dp
// Heap datapath: entry memory, moving entry, hole position, child select,
// pending popped entry and the output result register.
// ----------------------------------------------------------------------------
module tdmh_dp #(
    parameter int HEAP_DEPTH = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tdmh_pkg::cmd_t         cmd,
    output tdmh_pkg::stat_t        stat,
    input  logic [47:0]            due_time,
    input  logic [47:0]            current_time,
    input  logic [15:0]            handler_id,
    input  logic [31:0]            handler_arg,
    input  logic [15:0]            target_pe,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             status,
    output logic [47:0]            fired_deadline,
    output logic [15:0]            fired_handler,
    output logic [31:0]            fired_arg,
    output logic [15:0]            fired_pe,
    output logic                   last
);
    import tdmh_pkg::*;

    localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int CW = $clog2(HEAP_DEPTH + 1);

    // control state
    logic [CW-1:0] count_reg, count_next;
    logic          pend_valid_reg, pend_valid_next;
    logic          out_valid_reg, out_valid_next;

    // payload state
    logic [CW-1:0]     hole_reg, hole_next;
    logic [CW-1:0]     cpos_reg, cpos_next;
    entry_t            cur_reg, cur_next;
    entry_t            chosen_reg, chosen_next;
    entry_t            pend_reg, pend_next;
    logic [TIME_W-1:0] now_reg, now_next;
    status_t           out_status_reg, out_status_next;
    entry_t            out_entry_reg, out_entry_next;
    logic              out_last_reg, out_last_next;

    // memory port
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    entry_t            ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [$bits(entry_t)-1:0] ram_rdata;
    entry_t            rd;

    logic [CW:0] child;
    logic [CW:0] count_ext;
    logic [CW:0] parent_addr_w;
    logic [CW:0] left_addr_w;
    logic [CW-1:0] hole_addr_w;
    logic [CW-1:0] last_addr_w;

    assign rd        = entry_t'(ram_rdata);
    assign child     = {hole_reg, 1'b0};
    assign count_ext = {1'b0, count_reg};

    assign parent_addr_w = ({1'b0, hole_reg} >> 1) - (CW+1)'(1);
    assign left_addr_w   = child - (CW+1)'(1);
    assign hole_addr_w   = hole_reg - CW'(1);
    assign last_addr_w   = count_reg - CW'(1);

    tdmh_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (HEAP_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        stat.full         = (count_reg == CW'(HEAP_DEPTH));
        stat.count_zero   = (count_reg == '0);
        stat.hole_root    = (hole_reg == CW'(1));
        stat.up_less      = (cur_reg.deadline < rd.deadline);
        stat.due          = (count_reg != '0) && (rd.deadline < now_reg);
        stat.pend_valid   = pend_valid_reg;
        stat.child_over   = (child > count_ext);
        stat.right_exists = (child < count_ext);
        stat.right_less   = (chosen_reg.deadline > rd.deadline);
        stat.down_stop    = (cur_reg.deadline <= chosen_reg.deadline);
        stat.out_free     = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        hole_next       = hole_reg;
        cpos_next       = cpos_reg;
        cur_next        = cur_reg;
        chosen_next     = chosen_reg;
        pend_next       = pend_reg;
        now_next        = now_reg;
        out_status_next = out_status_reg;
        out_entry_next  = out_entry_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = hole_addr_w[AW-1:0];
        ram_wdata       = cur_reg;
        ram_raddr       = '0;

        case (cmd.op)
            OP_ACCEPT:
            begin
                cur_next.deadline = due_time;
                cur_next.handler  = handler_id;
                cur_next.arg      = handler_arg;
                cur_next.pe       = target_pe;
                now_next          = current_time;
                pend_valid_next   = 1'b0;
            end
            OP_SCHED:
            begin
                count_next = count_reg + CW'(1);
                hole_next  = count_reg + CW'(1);
            end
            OP_RD_PARENT:
            begin
                ram_raddr = parent_addr_w[AW-1:0];
            end
            OP_UP_MOVE:
            begin
                // parent slides down into the hole
                ram_we    = 1'b1;
                ram_wdata = rd;
                hole_next = hole_reg >> 1;
            end
            OP_WR_CUR:
            begin
                ram_we = 1'b1;
            end
            OP_RD_ROOT:
            begin
                ram_raddr = '0;
            end
            OP_POP:
            begin
                pend_next       = rd;
                pend_valid_next = 1'b1;
                count_next      = count_reg - CW'(1);
                ram_raddr       = last_addr_w[AW-1:0];
            end
            OP_LOAD_LAST:
            begin
                cur_next  = rd;
                hole_next = CW'(1);
            end
            OP_RD_LEFT:
            begin
                ram_raddr = left_addr_w[AW-1:0];
            end
            OP_TAKE_LEFT:
            begin
                chosen_next = rd;
                cpos_next   = child[CW-1:0];
                ram_raddr   = child[AW-1:0];
            end
            OP_TAKE_RIGHT:
            begin
                if (stat.right_less)
                begin
                    chosen_next = rd;
                    cpos_next   = child[CW-1:0] + CW'(1);
                end
            end
            OP_DOWN_MOVE:
            begin
                // earlier child moves up into the hole
                ram_we    = 1'b1;
                ram_wdata = chosen_reg;
                hole_next = cpos_reg;
            end
            OP_EMIT:
            begin
                out_valid_next  = 1'b1;
                out_status_next = cmd.res_status;
                out_last_next   = cmd.res_last;
                out_entry_next  = cmd.res_pend ? pend_reg : '0;
                if (cmd.res_pend)
                begin
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hole_reg       <= hole_next;
        cpos_reg       <= cpos_next;
        cur_reg        <= cur_next;
        chosen_reg     <= chosen_next;
        pend_reg       <= pend_next;
        now_reg        <= now_next;
        out_status_reg <= out_status_next;
        out_entry_reg  <= out_entry_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign fired_deadline = out_entry_reg.deadline;
    assign fired_handler  = out_entry_reg.handler;
    assign fired_arg      = out_entry_reg.arg;
    assign fired_pe       = out_entry_reg.pe;
    assign last           = out_last_reg;

endmodule

// ===== design/tdmh_ctrl.sv =====
// ----------------------------------------------------------------------------
// tdmh_ctrl
// Sequencer of the timer heap: accepts requests, walks sift-up for a
// schedule and repeated pop plus sift-down for an expire, and issues results.
// ----------------------------------------------------------------------------
module tdmh_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            kind,
    input  tdmh_pkg::stat_t stat,
    output tdmh_pkg::cmd_t  cmd
);
    import tdmh_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_SCH       = 4'd1;
    localparam logic [3:0] S_UP_CHK    = 4'd2;
    localparam logic [3:0] S_UP_CMP    = 4'd3;
    localparam logic [3:0] S_SCH_EMIT  = 4'd4;
    localparam logic [3:0] S_FULL_EMIT = 4'd5;
    localparam logic [3:0] S_EX_RD     = 4'd6;
    localparam logic [3:0] S_EX_TEST   = 4'd7;
    localparam logic [3:0] S_EX_MID    = 4'd8;
    localparam logic [3:0] S_POP_LAST  = 4'd9;
    localparam logic [3:0] S_SD_CHK    = 4'd10;
    localparam logic [3:0] S_SD_LEFT   = 4'd11;
    localparam logic [3:0] S_SD_RIGHT  = 4'd12;
    localparam logic [3:0] S_SD_DEC    = 4'd13;
    localparam logic [3:0] S_EX_FINAL  = 4'd14;

    logic [3:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd.op         = OP_NONE;
        cmd.res_status = ST_SCHEDULED;
        cmd.res_pend   = 1'b0;
        cmd.res_last   = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_ACCEPT;
                    state_next = kind ? S_EX_RD : S_SCH;
                end
            end
            S_SCH:
            begin
                if (stat.full)
                begin
                    state_next = S_FULL_EMIT;
                end
                else
                begin
                    cmd.op     = OP_SCHED;
                    state_next = S_UP_CHK;
                end
            end
            S_UP_CHK:
            begin
                if (stat.hole_root)
                begin
                    cmd.op     = OP_WR_CUR;
                    state_next = S_SCH_EMIT;
                end
                else
                begin
                    cmd.op     = OP_RD_PARENT;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (stat.up_less)
                begin
                    cmd.op     = OP_UP_MOVE;
                    state_next = S_UP_CHK;
                end
                else
                begin
                    cmd.op     = OP_WR_CUR;
                    state_next = S_SCH_EMIT;
                end
            end
            S_SCH_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            S_FULL_EMIT:
            begin
                cmd.res_status = ST_FULL;
                if (stat.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            S_EX_RD:
            begin
                cmd.op     = OP_RD_ROOT;
                state_next = S_EX_TEST;
            end
            S_EX_TEST:
            begin
                if (!stat.due)
                begin
                    state_next = S_EX_FINAL;
                end
                else if (stat.pend_valid)
                begin
                    // another pop follows, so the held entry is not the last
                    state_next = S_EX_MID;
                end
                else
                begin
                    cmd.op     = OP_POP;
                    state_next = S_POP_LAST;
                end
            end
            S_EX_MID:
            begin
                cmd.res_status = ST_DUE;
                cmd.res_pend   = 1'b1;
                cmd.res_last   = 1'b0;
                if (stat.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = S_EX_RD;
                end
            end
            S_POP_LAST:
            begin
                if (stat.count_zero)
                begin
                    state_next = S_EX_RD;
                end
                else
                begin
                    cmd.op     = OP_LOAD_LAST;
                    state_next = S_SD_CHK;
                end
            end
            S_SD_CHK:
            begin
                if (stat.child_over)
                begin
                    cmd.op     = OP_WR_CUR;
                    state_next = S_EX_RD;
                end
                else
                begin
                    cmd.op     = OP_RD_LEFT;
                    state_next = S_SD_LEFT;
                end
            end
            S_SD_LEFT:
            begin
                cmd.op     = OP_TAKE_LEFT;
                state_next = stat.right_exists ? S_SD_RIGHT : S_SD_DEC;
            end
            S_SD_RIGHT:
            begin
                cmd.op     = OP_TAKE_RIGHT;
                state_next = S_SD_DEC;
            end
            S_SD_DEC:
            begin
                if (stat.down_stop)
                begin
                    cmd.op     = OP_WR_CUR;
                    state_next = S_EX_RD;
                end
                else
                begin
                    cmd.op     = OP_DOWN_MOVE;
                    state_next = S_SD_CHK;
                end
            end
            S_EX_FINAL:
            begin
                cmd.res_status = stat.pend_valid ? ST_DUE : ST_NONE;
                cmd.res_pend   = stat.pend_valid;
                if (stat.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/timer_deadline_min_heap.sv =====
// ----------------------------------------------------------------------------
// timer_deadline_min_heap
// Timer queue kept as a one-based binary min-heap of deadlines with handler
// id, argument and target processor; schedules entries and expires due ones.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+--------------------------------------------
//  in      | in_valid, in_ready  | kind, due_time, current_time, handler_id,
//          |                     | handler_arg, target_pe
//  out     | out_valid,out_ready | status, fired_deadline, fired_handler,
//          |                     | fired_arg, fired_pe, last
//
//  one request at a time; the heap is a single RAM with one registered read
//  schedule: the new entry climbs one level per parent read and compare until
//  it reaches the root or a parent not later than it; status full when full
//  expire: the root is read and tested, status none when nothing is due; each
//  due root is popped and the last entry sunk from the root level by level;
//  each later pop first issues the previous result
//  reset clears the entry count and control flags; no memory clearing pass
//  a result waiting in the output register stalls the sequencer at its next
//  result only; sifting continues meanwhile
// ----------------------------------------------------------------------------
module timer_deadline_min_heap #(
    parameter int HEAP_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [47:0] due_time,
    input  logic [47:0] current_time,
    input  logic [15:0] handler_id,
    input  logic [31:0] handler_arg,
    input  logic [15:0] target_pe,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [47:0] fired_deadline,
    output logic [15:0] fired_handler,
    output logic [31:0] fired_arg,
    output logic [15:0] fired_pe,
    output logic        last
);
    import tdmh_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    tdmh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .stat     (stat),
        .cmd      (cmd)
    );

    tdmh_dp #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .due_time       (due_time),
        .current_time   (current_time),
        .handler_id     (handler_id),
        .handler_arg    (handler_arg),
        .target_pe      (target_pe),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .fired_deadline (fired_deadline),
        .fired_handler  (fired_handler),
        .fired_arg      (fired_arg),
        .fired_pe       (fired_pe),
        .last           (last)
    );

`ifndef ASSERT_OFF
    // a pending result is never overwritten
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_EMIT |-> stat.out_free)
        else $error("result issued while output register busy");

    // a popped entry is only reported while held
    a_emit_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_EMIT && cmd.res_pend) |-> stat.pend_valid)
        else $error("due result issued without a popped entry");

    // never append past capacity
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_SCHED |-> !stat.full)
        else $error("schedule appended to a full heap");

    // nothing held over between requests
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !stat.pend_valid)
        else $error("popped entry left behind at idle");
`endif

endmodule
